[sv/bta_pkg.sv]
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the block table page allocator: entry
// encoding, status codes, register indexes and the control interface.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int ACC_W = 33;

    localparam logic [7:0] TYPE_MASK  = 8'h0f;
    localparam logic [7:0] TYPE_FREE  = 8'h00;
    localparam logic [7:0] TYPE_TAKEN = 8'h01;
    localparam logic [7:0] FLAG_FIRST = 8'h40;
    localparam logic [7:0] FLAG_NEXT  = 8'h80;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_RUN   = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_BLOCKS    = 1'b1;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_START,
        OP_SCAN,
        OP_MARK,
        OP_SEEK,
        OP_WALK
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_use_addr;
    } bta_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic zero_size;
        logic scan_end;
        logic found;
        logic oversize;
        logic mark_last;
        logic seek_bad;
        logic seek_hit;
        logic head_ok;
        logic walk_last;
    } bta_stat_t;

endpackage

[sv/bta_ctrl.sv]
// ----------------------------------------------------------------------------
// bta_ctrl
// Sequencer of the allocator: clearing pass, request dispatch, first-fit
// scan, run marking, free address search, chain walk and result hand-off.
// ----------------------------------------------------------------------------
module bta_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                kind,
    output logic                in_stall,
    input  logic                out_stall,
    output logic                out_valid,
    output bta_pkg::bta_cmd_t   cmd,
    input  bta_pkg::bta_stat_t  stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_SEEK,
        S_CHECK,
        S_WALK,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;
    logic       use_addr_reg, use_addr_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        code_next        = code_reg;
        use_addr_next    = use_addr_reg;
        cmd.op           = bta_pkg::OP_HOLD;
        cmd.out_load     = 1'b0;
        cmd.out_status   = code_reg;
        cmd.out_use_addr = use_addr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = bta_pkg::OP_CLEAR;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = bta_pkg::OP_START;
                    state_next = (kind == bta_pkg::KIND_FREE) ? S_SEEK : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = bta_pkg::OP_SCAN;
                if (stat.zero_size)
                begin
                    code_next     = bta_pkg::ST_BAD_SIZE;
                    use_addr_next = 1'b0;
                    state_next    = S_DONE;
                end
                else if (stat.scan_end)
                begin
                    code_next     = stat.oversize ? bta_pkg::ST_BAD_SIZE : bta_pkg::ST_NO_RUN;
                    use_addr_next = 1'b0;
                    state_next    = S_DONE;
                end
                else if (stat.found)
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.op = bta_pkg::OP_MARK;
                if (stat.mark_last)
                begin
                    code_next     = bta_pkg::ST_OK;
                    use_addr_next = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_SEEK:
            begin
                cmd.op = bta_pkg::OP_SEEK;
                if (stat.seek_bad)
                begin
                    code_next     = bta_pkg::ST_BAD_FREE;
                    use_addr_next = 1'b0;
                    state_next    = S_DONE;
                end
                else if (stat.seek_hit)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.head_ok)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    code_next     = bta_pkg::ST_BAD_FREE;
                    use_addr_next = 1'b0;
                    state_next    = S_DONE;
                end
            end
            S_WALK:
            begin
                cmd.op = bta_pkg::OP_WALK;
                if (stat.walk_last)
                begin
                    code_next     = bta_pkg::ST_OK;
                    use_addr_next = 1'b0;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            code_reg      <= bta_pkg::ST_OK;
            use_addr_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            use_addr_reg  <= use_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("A result was loaded over one not yet taken.");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("A loaded result is not presented.");

endmodule

[sv/bta_dpath.sv]
// ----------------------------------------------------------------------------
// bta_dpath
// Datapath of the allocator: configuration registers, block table memory,
// index and byte offset counters, run tracking and the result register.
// ----------------------------------------------------------------------------
module bta_dpath #(
    parameter int MAX_BLOCKS = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic [31:0]         alloc_bytes,
    input  logic [31:0]         free_address,
    output logic [31:0]         result_address,
    output logic [1:0]          status,
    input  bta_pkg::bta_cmd_t   cmd,
    output bta_pkg::bta_stat_t  stat
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int TOT_W = (CNT_W > 11) ? CNT_W : 11;
    localparam int AW    = bta_pkg::ACC_W;
    localparam logic [AW-1:0] PAGE_INC = AW'(PAGE_BYTES);

    logic [31:0]      heap_base_reg;
    logic [10:0]      blocks_reg;
    logic [31:0]      bytes_reg;
    logic [31:0]      free_addr_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [AW-1:0]    acc_reg, acc_next;
    logic [AW-1:0]    run_reg, run_next;
    logic [IDX_W-1:0] start_idx_reg, start_idx_next;
    logic [AW-1:0]    start_off_reg, start_off_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [31:0]      res_addr_reg;
    logic [1:0]       res_status_reg;

    logic [7:0]       mem [MAX_BLOCKS];
    logic [7:0]       rd_data;
    logic             wr_en;
    logic [7:0]       wr_data;

    logic [TOT_W-1:0] blocks_ext;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] idx_plus;
    logic [IDX_W-1:0] idx_low;
    logic [IDX_W-1:0] start_now;
    logic [AW-1:0]    run_new;
    logic [AW-1:0]    off_ext;
    logic             entry_free;
    logic             below_base;
    logic [7:0]       mark_entry;

    assign blocks_ext = TOT_W'(blocks_reg);
    assign total      = (blocks_ext > TOT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                          : CNT_W'(blocks_ext);
    assign idx_plus   = idx_reg + CNT_W'(1);
    assign idx_low    = idx_reg[IDX_W-1:0];
    assign start_now  = (run_reg == '0) ? idx_low : start_idx_reg;
    assign run_new    = run_reg + PAGE_INC;
    assign entry_free = ((rd_data & bta_pkg::TYPE_MASK) == bta_pkg::TYPE_FREE);
    assign below_base = (free_addr_reg < heap_base_reg);
    assign off_ext    = AW'(free_addr_reg - heap_base_reg);

    always_comb
    begin
        mark_entry = bta_pkg::TYPE_TAKEN;
        if (idx_low == start_idx_reg)
        begin
            mark_entry = mark_entry | bta_pkg::FLAG_FIRST;
        end
        if (idx_low != last_idx_reg)
        begin
            mark_entry = mark_entry | bta_pkg::FLAG_NEXT;
        end
    end

    always_comb
    begin
        stat.clear_last = (idx_reg == CNT_W'(MAX_BLOCKS - 1));
        stat.zero_size  = (bytes_reg == 32'd0);
        stat.scan_end   = (idx_reg >= total);
        stat.found      = !stat.scan_end && entry_free && (run_new >= AW'(bytes_reg));
        stat.oversize   = (AW'(bytes_reg) > acc_reg);
        stat.mark_last  = (idx_low == last_idx_reg);
        stat.seek_bad   = below_base || (idx_reg >= total) || (acc_reg > off_ext);
        stat.seek_hit   = (acc_reg == off_ext);
        stat.head_ok    = ((rd_data & bta_pkg::TYPE_MASK) == bta_pkg::TYPE_TAKEN)
                          && ((rd_data & bta_pkg::FLAG_FIRST) != 8'h00);
        stat.walk_last  = ((rd_data & bta_pkg::FLAG_NEXT) == 8'h00) || (idx_plus >= total);
    end

    always_comb
    begin
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        run_next       = run_reg;
        start_idx_next = start_idx_reg;
        start_off_next = start_off_reg;
        last_idx_next  = last_idx_reg;
        wr_en          = 1'b0;
        wr_data        = bta_pkg::TYPE_FREE;
        case (cmd.op)
            bta_pkg::OP_CLEAR:
            begin
                wr_en    = 1'b1;
                idx_next = stat.clear_last ? '0 : idx_plus;
            end
            bta_pkg::OP_START:
            begin
                idx_next = '0;
                acc_next = '0;
                run_next = '0;
            end
            bta_pkg::OP_SCAN:
            begin
                if (!stat.scan_end)
                begin
                    last_idx_next = idx_low;
                    acc_next      = acc_reg + PAGE_INC;
                    if (entry_free)
                    begin
                        run_next = run_new;
                        if (run_reg == '0)
                        begin
                            start_idx_next = idx_low;
                            start_off_next = acc_reg;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                    idx_next = stat.found ? CNT_W'(start_now) : idx_plus;
                end
            end
            bta_pkg::OP_MARK:
            begin
                wr_en   = 1'b1;
                wr_data = mark_entry;
                if (!stat.mark_last)
                begin
                    idx_next = idx_plus;
                end
            end
            bta_pkg::OP_SEEK:
            begin
                if (!stat.seek_bad && !stat.seek_hit)
                begin
                    idx_next = idx_plus;
                    acc_next = acc_reg + PAGE_INC;
                end
            end
            bta_pkg::OP_WALK:
            begin
                wr_en = 1'b1;
                if (!stat.walk_last)
                begin
                    idx_next = idx_plus;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The table is read at the next index, so rd_data holds the entry at idx_reg before any write to it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_low] <= wr_data;
        end
        rd_data <= mem[idx_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= 32'd0;
            blocks_reg    <= 11'd1024;
            idx_reg       <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    bta_pkg::CFG_HEAP_BASE: heap_base_reg <= cfg_data;
                    bta_pkg::CFG_BLOCKS:    blocks_reg    <= cfg_data[10:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        run_reg       <= run_next;
        start_idx_reg <= start_idx_next;
        start_off_reg <= start_off_next;
        last_idx_reg  <= last_idx_next;
        if (cmd.op == bta_pkg::OP_START)
        begin
            bytes_reg     <= alloc_bytes;
            free_addr_reg <= free_address;
        end
        if (cmd.out_load)
        begin
            res_addr_reg   <= cmd.out_use_addr ? (heap_base_reg + start_off_reg[31:0]) : 32'd0;
            res_status_reg <= cmd.out_status;
        end
    end

    assign result_address = res_addr_reg;
    assign status         = res_status_reg;

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bta_pkg::OP_MARK) |-> (idx_reg < total))
        else $error("Run marking went past the covered blocks.");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bta_pkg::OP_WALK) |-> (idx_reg < total))
        else $error("Chain walk went past the covered blocks.");

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bta_pkg::OP_SCAN) |-> (run_reg <= acc_reg))
        else $error("Free run is longer than the scanned part of the table.");

endmodule

[sv/block_table_page_allocator.sv]
// ----------------------------------------------------------------------------
// block_table_page_allocator
// Page-granular first-fit heap allocator over a block table: allocate
// requests claim a run of free pages, free requests release a chain.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_stall   kind, alloc_bytes, free_address
//  out      out_valid / out_stall result_address, status
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  An allocate request scans the table entries for a free run and then marks the
//  pages claimed; the scan reads one entry a cycle.
//  A free request seeks block b, checks its head entry and walks its chain of c pages.
//  After reset a clearing pass frees every table entry before any request is taken.
//  The result register holds a stalled result while the next request is accepted.
// ----------------------------------------------------------------------------
module block_table_page_allocator #(
    parameter int MAX_BLOCKS = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] alloc_bytes,
    input  logic [31:0] free_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_address,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    bta_pkg::bta_cmd_t  cmd;
    bta_pkg::bta_stat_t stat;

    assign cfg_ready = 1'b1;

    bta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    bta_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .alloc_bytes    (alloc_bytes),
        .free_address   (free_address),
        .result_address (result_address),
        .status         (status),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
